// ===== design/rtc_pkg.sv =====
package rtc_pkg;

	localparam int SIZE_W = 13;
	localparam int ALPHA_W = 8;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_LINE_CHECK_EN = 2'd2
	} cfg_reg_t;

	localparam logic [SIZE_W-1:0] WIDTH_RESET = 13'd2048;
	localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd2048;

	typedef struct packed {
		logic all_transparent;
		logic empty_line_found;
		logic image_ok;
	} result_t;

	localparam int QCNT_W = 2;

endpackage

// ===== design/rtc_colmem.sv =====
module rtc_colmem #(
	parameter int DEPTH = 4096,
	parameter int AW = 12
) (
	input  logic          clk,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic          rdata,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata
);

	logic mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/rtc_outq.sv =====
module rtc_outq (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              enq,
	input  rtc_pkg::result_t                  enq_data,
	input  logic                              deq_ready,
	output logic                              deq_valid,
	output rtc_pkg::result_t                  deq_data,
	output logic [rtc_pkg::QCNT_W-1:0]        count
);

	rtc_pkg::result_t entry_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [rtc_pkg::QCNT_W-1:0] count_q;
	logic deq;

	assign deq_valid = count_q != '0;
	assign deq_data = entry_q[rd_ptr_q];
	assign count = count_q;
	assign deq = deq_valid & deq_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (deq) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (enq && !deq) begin
				count_q <= count_q + rtc_pkg::QCNT_W'(1);
			end else if (!enq && deq) begin
				count_q <= count_q - rtc_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (enq) begin
			entry_q[wr_ptr_q] <= enq_data;
		end
	end

endmodule

// ===== design/rgba_transparency_checker_core.sv =====
// channel  | handshake             | payload
// pixel    | in_valid / in_ready   | alpha
// result   | out_valid / out_ready | all_transparent, empty_line_found, image_ok
// config   | cfg_we                | cfg_index, cfg_data
//
// one pixel per cycle while in_ready is high; the column bit memory is read on
// accept and written back in the cycle after, with forwarding when the same column
// is hit twice in a row. a finished image's result passes stage 1, then the queue.
// a two-entry result queue absorbs stalls; in_ready drops only when the queue
// could overflow. reset clears all control state, the column memory is not cleared.
module rgba_transparency_checker_core #(
	parameter int MAX_WIDTH = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [rtc_pkg::ALPHA_W-1:0]       alpha,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              all_transparent,
	output logic                              empty_line_found,
	output logic                              image_ok,
	input  logic                              cfg_we,
	input  logic [rtc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rtc_pkg::SIZE_W-1:0]        cfg_data
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int CMPW0 = (CW > RW) ? CW + 1 : RW + 1;
	localparam int CMPW = (CMPW0 > rtc_pkg::SIZE_W + 1) ? CMPW0 : rtc_pkg::SIZE_W + 1;

	typedef struct packed {
		logic zero;
		logic first_row;
		logic last_row;
		logic row_line;
		logic last_image;
		logic all_clear;
		logic line_en;
	} pix_info_t;

	logic [rtc_pkg::SIZE_W-1:0] width_q;
	logic [rtc_pkg::SIZE_W-1:0] height_q;
	logic line_en_q;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic row_clear_q;
	logic img_clear_q;
	logic any_line_q;

	logic s1_valid;
	logic [CW-1:0] addr_s1;
	pix_info_t info_s1;
	logic fwd_hit_s1;
	logic fwd_bit_s1;

	logic acc;
	logic zero;
	logic [CMPW-1:0] w_eff;
	logic [CMPW-1:0] h_eff;
	logic last_col;
	logic last_row;
	logic rc;
	logic img_next;

	logic rd_bit;
	logic col_bit;
	logic cc;
	logic any_next;
	logic s1_res;
	rtc_pkg::result_t res;
	rtc_pkg::result_t head;
	logic [rtc_pkg::QCNT_W-1:0] q_count;
	logic [rtc_pkg::QCNT_W:0] occ;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= rtc_pkg::WIDTH_RESET;
			height_q <= rtc_pkg::HEIGHT_RESET;
			line_en_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				rtc_pkg::REG_IMAGE_WIDTH: width_q <= cfg_data;
				rtc_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
				rtc_pkg::REG_LINE_CHECK_EN: line_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// stage 0: position tracking and row flags
	always_comb begin
		acc = in_valid & in_ready;
		zero = alpha == '0;
		if (width_q == '0) begin
			w_eff = CMPW'(1);
		end else if (CMPW'(width_q) > CMPW'(MAX_WIDTH)) begin
			w_eff = CMPW'(MAX_WIDTH);
		end else begin
			w_eff = CMPW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = CMPW'(1);
		end else if (CMPW'(height_q) > CMPW'(MAX_HEIGHT)) begin
			h_eff = CMPW'(MAX_HEIGHT);
		end else begin
			h_eff = CMPW'(height_q);
		end
		last_col = (CMPW'(col_q) + CMPW'(1)) >= w_eff;
		last_row = (CMPW'(row_q) + CMPW'(1)) >= h_eff;
		rc = ((col_q == '0) | row_clear_q) & zero;
		img_next = img_clear_q & zero;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			row_clear_q <= 1'b1;
			img_clear_q <= 1'b1;
			s1_valid <= 1'b0;
		end else begin
			s1_valid <= acc;
			if (acc) begin
				row_clear_q <= rc;
				if (last_col) begin
					col_q <= '0;
					if (last_row) begin
						row_q <= '0;
						img_clear_q <= 1'b1;
					end else begin
						row_q <= row_q + RW'(1);
						img_clear_q <= img_next;
					end
				end else begin
					col_q <= col_q + CW'(1);
					img_clear_q <= img_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			addr_s1 <= col_q;
			info_s1.zero <= zero;
			info_s1.first_row <= row_q == '0;
			info_s1.last_row <= last_row;
			info_s1.row_line <= last_col & rc;
			info_s1.last_image <= last_col & last_row;
			info_s1.all_clear <= img_next;
			info_s1.line_en <= line_en_q;
			fwd_hit_s1 <= s1_valid && (addr_s1 == col_q);
			fwd_bit_s1 <= cc;
		end
	end

	rtc_colmem #(
		.DEPTH(MAX_WIDTH),
		.AW(CW)
	) u_colmem (
		.clk(clk),
		.re(acc),
		.raddr(col_q),
		.rdata(rd_bit),
		.we(s1_valid),
		.waddr(addr_s1),
		.wdata(cc)
	);

	// stage 1: column read-modify-write and image result
	always_comb begin
		col_bit = fwd_hit_s1 ? fwd_bit_s1 : rd_bit;
		cc = (info_s1.first_row | col_bit) & info_s1.zero;
		any_next = any_line_q | (info_s1.last_row & cc) | info_s1.row_line;
		s1_res = s1_valid & info_s1.last_image;
		res.all_transparent = info_s1.all_clear;
		res.empty_line_found = any_next & info_s1.line_en;
		res.image_ok = ~info_s1.all_clear & ~(any_next & info_s1.line_en);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_line_q <= 1'b0;
		end else if (s1_valid) begin
			any_line_q <= info_s1.last_image ? 1'b0 : any_next;
		end
	end

	rtc_outq u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.enq(s1_res),
		.enq_data(res),
		.deq_ready(out_ready),
		.deq_valid(out_valid),
		.deq_data(head),
		.count(q_count)
	);

	// queue space check, counting a result still in flight
	always_comb begin
		occ = {1'b0, q_count} + {{rtc_pkg::QCNT_W{1'b0}}, s1_res}
			- {{rtc_pkg::QCNT_W{1'b0}}, out_valid & out_ready};
		in_ready = occ <= (rtc_pkg::QCNT_W + 1)'(1);
	end

	assign all_transparent = head.all_transparent;
	assign empty_line_found = head.empty_line_found;
	assign image_ok = head.image_ok;

endmodule

// ===== design/rtc_checker.sv =====
module rtc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic [rtc_pkg::ALPHA_W-1:0]       alpha,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic                              all_transparent,
	input logic                              empty_line_found,
	input logic                              image_ok,
	input logic                              cfg_we,
	input logic [rtc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input logic [rtc_pkg::SIZE_W-1:0]        cfg_data
);

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid
			&& $stable(all_transparent) && $stable(empty_line_found) && $stable(image_ok))
		else $error("result changed while stalled");

	// pass flag agrees with the two fault flags
	a_ok_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> image_ok == !(all_transparent || empty_line_found))
		else $error("image_ok inconsistent");

	// a fresh result traces back to an accepted pixel request through stage 1 and the queue
	a_res_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without pixel");

	// a result is never both transparent and ok
	a_all_not_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && all_transparent |-> !image_ok)
		else $error("transparent image reported ok");

endmodule

bind rgba_transparency_checker_core rtc_checker u_rtc_checker (.*);

// ===== verif/rgba_transparency_checker_core_tb.sv =====
`timescale 1ns / 1ps

module rgba_transparency_checker_core_tb;

	localparam int MAX_W = 4096;
	localparam int MAX_H = 4096;
	localparam logic [rtc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 4;

	typedef enum int {
		PAT_CLEAR,
		PAT_MIXED,
		PAT_ZERO_ROW,
		PAT_ZERO_COL,
		PAT_OPAQUE,
		PAT_ONE_DOT
	} pattern_t;

	class alpha_flag_scoreboard;
		logic [rtc_pkg::SIZE_W-1:0] width_reg;
		logic [rtc_pkg::SIZE_W-1:0] height_reg;
		logic line_check;
		bit col_clear [MAX_W];
		bit row_clear;
		bit any_line;
		bit image_clear;
		logic [11:0] col_pos;
		logic [11:0] row_pos;
		rtc_pkg::result_t flags_q [$];
		int errors;
		int results;

		function new();
			width_reg = rtc_pkg::WIDTH_RESET;
			height_reg = rtc_pkg::HEIGHT_RESET;
			line_check = 1'b0;
			errors = 0;
			results = 0;
			restart();
		endfunction

		function void restart();
			row_clear = 1'b1;
			any_line = 1'b0;
			image_clear = 1'b1;
			col_pos = '0;
			row_pos = '0;
		endfunction

		function int clamp(logic [rtc_pkg::SIZE_W-1:0] v, int lim);
			if (v == 0)
				return 1;
			return (int'(v) > lim) ? lim : int'(v);
		endfunction

		function int eff_width();
			return clamp(width_reg, MAX_W);
		endfunction

		function int eff_height();
			return clamp(height_reg, MAX_H);
		endfunction

		function int pending();
			return flags_q.size();
		endfunction

		function void set_reg(logic [rtc_pkg::CFG_IDX_W-1:0] idx,
				logic [rtc_pkg::SIZE_W-1:0] val);
			case (idx)
				rtc_pkg::REG_IMAGE_WIDTH: width_reg = val;
				rtc_pkg::REG_IMAGE_HEIGHT: height_reg = val;
				rtc_pkg::REG_LINE_CHECK_EN: line_check = val[0];
				default: ;
			endcase
		endfunction

		function void note_pixel(logic [rtc_pkg::ALPHA_W-1:0] a);
			int w;
			int h;
			bit zero;
			bit last_col;
			bit last_row;
			bit cc;
			bit rc;
			rtc_pkg::result_t r;
			w = eff_width();
			h = eff_height();
			zero = (a == 0);
			last_col = (int'(col_pos) + 1 >= w);
			last_row = (int'(row_pos) + 1 >= h);
			cc = (row_pos == 0 || col_clear[col_pos]) && zero;
			col_clear[col_pos] = cc;
			rc = (col_pos == 0 || row_clear) && zero;
			row_clear = rc;
			image_clear = image_clear && zero;
			if ((last_row && cc) || (last_col && rc))
				any_line = 1'b1;
			if (!last_col) begin
				col_pos++;
				return;
			end
			col_pos = '0;
			if (!last_row) begin
				row_pos++;
				return;
			end
			r.all_transparent = image_clear;
			r.empty_line_found = any_line && line_check;
			r.image_ok = !image_clear && !r.empty_line_found;
			flags_q.push_back(r);
			restart();
		endfunction

		function void compare_bit(string field, logic want, logic got);
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("mismatch on result %0d, %s: expected %b, got %b",
						results, field, want, got);
			end
		endfunction

		function void check_flags(rtc_pkg::result_t got);
			rtc_pkg::result_t want;
			results++;
			if (flags_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result %0d (%b) arrived with no image finished", results, got);
				return;
			end
			want = flags_q.pop_front();
			compare_bit("all_transparent", want.all_transparent, got.all_transparent);
			compare_bit("empty_line_found", want.empty_line_found, got.empty_line_found);
			compare_bit("image_ok", want.image_ok, got.image_ok);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [rtc_pkg::ALPHA_W-1:0] alpha = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic all_transparent;
	logic empty_line_found;
	logic image_ok;
	logic cfg_we = 1'b0;
	logic [rtc_pkg::CFG_IDX_W-1:0] cfg_index = rtc_pkg::REG_IMAGE_WIDTH;
	logic [rtc_pkg::SIZE_W-1:0] cfg_data = '0;

	int src_idle = 0;
	int sink_stall = 0;
	int pixel_count = 0;
	alpha_flag_scoreboard sb = new();

	rgba_transparency_checker_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.alpha(alpha),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.all_transparent(all_transparent),
		.empty_line_found(empty_line_found),
		.image_ok(image_ok),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= sink_stall);
	end

	always @(posedge clk) begin
		rtc_pkg::result_t got;
		if (arst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
			got.all_transparent = all_transparent;
			got.empty_line_found = empty_line_found;
			got.image_ok = image_ok;
			sb.check_flags(got);
		end
	end

	task automatic send_pixel(input logic [rtc_pkg::ALPHA_W-1:0] a);
		while ($urandom_range(99) < src_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		alpha <= a;
		@(posedge clk);
		while (in_ready !== 1'b1)
			@(posedge clk);
		sb.note_pixel(a);
		pixel_count++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [rtc_pkg::CFG_IDX_W-1:0] idx,
			input logic [rtc_pkg::SIZE_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// pad the current image out to its last pixel
	task automatic finish_image();
		while (sb.col_pos != 0 || sb.row_pos != 0)
			send_pixel(($urandom_range(1) == 0) ? '0
				: rtc_pkg::ALPHA_W'($urandom_range(1, 255)));
	endtask

	task automatic send_image(input pattern_t pattern);
		int w;
		int h;
		int zr;
		int zc;
		int hot;
		logic [rtc_pkg::ALPHA_W-1:0] a;
		logic [rtc_pkg::ALPHA_W-1:0] noisy;
		w = sb.eff_width();
		h = sb.eff_height();
		zr = $urandom_range(h - 1);
		zc = $urandom_range(w - 1);
		hot = $urandom_range(w * h - 1);
		for (int r = 0; r < h; r++) begin
			for (int c = 0; c < w; c++) begin
				noisy = ($urandom_range(9) == 0) ? '0
					: rtc_pkg::ALPHA_W'($urandom_range(1, 255));
				case (pattern)
					PAT_CLEAR: a = '0;
					PAT_MIXED: a = ($urandom_range(1) == 0) ? '0
						: rtc_pkg::ALPHA_W'($urandom_range(1, 255));
					PAT_ZERO_ROW: a = (r == zr) ? '0 : noisy;
					PAT_ZERO_COL: a = (c == zc) ? '0 : noisy;
					PAT_OPAQUE: a = rtc_pkg::ALPHA_W'($urandom_range(1, 255));
					default: a = (r * w + c == hot)
						? rtc_pkg::ALPHA_W'($urandom_range(1, 255)) : '0;
				endcase
				send_pixel(a);
			end
		end
	endtask

	function automatic logic [rtc_pkg::SIZE_W-1:0] pick_size();
		int roll;
		roll = $urandom_range(99);
		if (roll < 5)
			return '0;
		if (roll < 85)
			return rtc_pkg::SIZE_W'($urandom_range(1, 8));
		return rtc_pkg::SIZE_W'($urandom_range(9, 16));
	endfunction

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int idle_pct [4];
		int stall_pct [4];
		int phase_pixels;
		idle_pct = '{0, 45, 0, 15};
		stall_pct = '{0, 0, 45, 15};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// line check still at its reset value of off
		write_reg(rtc_pkg::REG_IMAGE_WIDTH, 13'd2);
		write_reg(rtc_pkg::REG_IMAGE_HEIGHT, 13'd2);
		send_image(PAT_ZERO_ROW);
		drain();
		write_reg(rtc_pkg::REG_LINE_CHECK_EN, 13'd1);
		send_image(PAT_ZERO_ROW);
		send_image(PAT_ZERO_COL);
		send_image(PAT_CLEAR);
		send_image(PAT_OPAQUE);
		send_image(PAT_ONE_DOT);

		// zero sizes act as one
		drain();
		write_reg(rtc_pkg::REG_IMAGE_WIDTH, 13'd0);
		write_reg(rtc_pkg::REG_IMAGE_HEIGHT, 13'd0);
		send_pixel(8'h00);
		send_pixel(8'hFF);

		drain();
		write_reg(REG_UNUSED, 13'h1FFF);
		write_reg(rtc_pkg::REG_LINE_CHECK_EN, 13'h1FFE);
		send_pixel(8'h00);
		send_pixel(8'h80);

		// width shrinks below the current column
		drain();
		write_reg(rtc_pkg::REG_LINE_CHECK_EN, 13'd1);
		write_reg(rtc_pkg::REG_IMAGE_WIDTH, 13'd6);
		write_reg(rtc_pkg::REG_IMAGE_HEIGHT, 13'd3);
		repeat (9) send_pixel(8'h00);
		drain();
		write_reg(rtc_pkg::REG_IMAGE_WIDTH, 13'd2);
		finish_image();

		// width grows while still in the first row
		drain();
		write_reg(rtc_pkg::REG_IMAGE_HEIGHT, 13'd2);
		send_pixel(8'h00);
		drain();
		write_reg(rtc_pkg::REG_IMAGE_WIDTH, 13'd4);
		finish_image();

		// height shrinks below the current row
		drain();
		write_reg(rtc_pkg::REG_IMAGE_WIDTH, 13'd2);
		write_reg(rtc_pkg::REG_IMAGE_HEIGHT, 13'd4);
		repeat (5) send_pixel(8'h00);
		drain();
		write_reg(rtc_pkg::REG_IMAGE_HEIGHT, 13'd2);
		finish_image();

		// height grows mid-image
		drain();
		repeat (3) send_pixel(8'h00);
		drain();
		write_reg(rtc_pkg::REG_IMAGE_HEIGHT, 13'd3);
		finish_image();

		// largest sizes and sizes past the maximum, left early by shrinking
		drain();
		write_reg(rtc_pkg::REG_IMAGE_WIDTH, 13'd4096);
		write_reg(rtc_pkg::REG_IMAGE_HEIGHT, 13'd1);
		repeat (5) send_pixel(8'h00);
		drain();
		write_reg(rtc_pkg::REG_IMAGE_WIDTH, 13'h1FFF);
		repeat (5) send_pixel(8'h00);
		drain();
		write_reg(rtc_pkg::REG_IMAGE_HEIGHT, 13'h1FFF);
		repeat (5) send_pixel(8'h00);
		drain();
		write_reg(rtc_pkg::REG_IMAGE_HEIGHT, 13'd1);
		write_reg(rtc_pkg::REG_IMAGE_WIDTH, 13'd2);
		finish_image();

		drain();
		write_reg(rtc_pkg::REG_IMAGE_WIDTH, 13'd4);
		write_reg(rtc_pkg::REG_IMAGE_HEIGHT, 13'd3);

		for (int p = 0; p < 4; p++) begin
			src_idle = idle_pct[p];
			sink_stall = stall_pct[p];
			phase_pixels = pixel_count + 280;
			while (pixel_count < phase_pixels) begin
				drain();
				if ($urandom_range(3) != 0)
					write_reg(rtc_pkg::REG_IMAGE_WIDTH, pick_size());
				if ($urandom_range(3) != 0)
					write_reg(rtc_pkg::REG_IMAGE_HEIGHT, pick_size());
				if ($urandom_range(2) == 0)
					write_reg(rtc_pkg::REG_LINE_CHECK_EN,
						rtc_pkg::SIZE_W'($urandom_range(8191)));
				repeat ($urandom_range(1, 3)) send_image(pattern_t'($urandom_range(0, 5)));
			end
		end

		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
